>>> hw/rtl/lane_follow_steering_controller_defines.svh
// ----------------------------------------------------------------------------
// Lane follow steering controller assertion macros
// Shared concurrent assertion forms for the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef LANE_FOLLOW_STEERING_CONTROLLER_DEFINES_SVH
`define LANE_FOLLOW_STEERING_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define LFSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// Lane follow steering controller package
// Types, codes, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsc_pkg;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_VEL  = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;
  localparam logic [1:0] ACT_FIN  = 2'd3;

  localparam logic [2:0] CFG_X_LOW    = 3'd0;
  localparam logic [2:0] CFG_X_HIGH   = 3'd1;
  localparam logic [2:0] CFG_STUCK_D  = 3'd2;
  localparam logic [2:0] CFG_STUCK_N  = 3'd3;
  localparam logic [2:0] CFG_ESCAPE_N = 3'd4;
  localparam logic [2:0] CFG_CURVE    = 3'd5;
  localparam logic [2:0] CFG_LOST_N   = 3'd6;

  localparam int PiQ         = 12868;
  localparam int TwoPiQ      = 25736;
  localparam int HalfPiQ     = 6434;
  localparam int TurnDoneTol = 204;
  localparam int TurnMin     = 410;
  localparam int TurnMax     = 2048;
  localparam int TurnRecip   = 838861; // ceil(2^23 / 10)
  localparam int KpQ         = 2458;
  localparam int KdQ         = 328;
  localparam int KpCurveOneQ = 3686;
  localparam int KdCurveOneQ = 393;
  localparam int ImuGainQ    = 3277;
  localparam int ImuLimitQ   = 1638;
  localparam int WBothQ      = 2048;
  localparam int WOneQ       = 819;
  localparam int FiltKeepQ   = 2458;
  localparam int FiltNewQ    = 1638;
  localparam int YawLimitQ   = 2458;
  localparam int SpeedBase   = 2048;
  localparam int SpeedCurve  = 1024;
  localparam int SpeedEscape = 2048;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DX, ST_DY, ST_SD, ST_CLS, ST_T1, ST_T2,
    ST_H1, ST_H2, ST_P1, ST_P2, ST_P3, ST_B1, ST_B2, ST_B3,
    ST_F1, ST_F2, ST_F3, ST_DONE
  } lfsc_state_t;

  typedef enum logic [3:0] {
    C_FIN, C_TDONE, C_TURN, C_JUNC, C_ESC, C_STUCK, C_LOST, C_STR, C_CRV
  } lfsc_cls_t;

  typedef enum logic [3:0] {
    M_DXDX, M_DYDY, M_SDSD, M_TURN, M_IMU, M_KPOFF, M_KDD,
    M_IMUW, M_VISW, M_FKEEP, M_FNEW
  } lfsc_msel_t;

  typedef enum logic [1:0] {
    MAC_HOLD, MAC_CLR, MAC_ADD, MAC_SUB
  } lfsc_mmode_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_TURN, CAP_IMU, CAP_PD, CAP_CMD, CAP_FILT
  } lfsc_cap_t;

  typedef struct packed {
    logic        load;
    logic        commit;
    logic        emit;
    lfsc_mmode_t mode;
    lfsc_msel_t  sel;
    lfsc_cap_t   cap;
  } lfsc_cmd_t;

  typedef struct packed {
    lfsc_cls_t cls_nxt;
    lfsc_cls_t cls;
    logic      out_free;
  } lfsc_sts_t;

  function automatic logic signed [16:0] wrap_angle(input logic signed [16:0] a);
    logic signed [16:0] r;
    r = a;
    if (a > 17'(PiQ)) begin
      r = a - 17'(TwoPiQ);
    end else if (a < -17'(PiQ)) begin
      r = a + 17'(TwoPiQ);
    end
    return r;
  endfunction

  // Q24 -> Q12, nearest, ties away from zero
  function automatic logic signed [36:0] rnd12(input logic signed [47:0] v);
    logic [47:0] m;
    logic [47:0] s;
    logic signed [36:0] q;
    m = v[47] ? 48'(-v) : 48'(v);
    s = m + 48'd2048;
    q = $signed({1'b0, s[47:12]});
    return v[47] ? -q : q;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lfsc_datapath.sv
// ----------------------------------------------------------------------------
// Lane follow steering controller datapath
// Config registers, controller state, shared multiply-accumulate unit,
// tick classification and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lane_follow_steering_controller_defines.svh"

module lfsc_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [19:0]           cfg_data,
  input  wire logic signed [19:0]    in_position_x,
  input  wire logic signed [19:0]    in_position_y,
  input  wire logic signed [14:0]    in_heading,
  input  wire logic                  in_lane_seen,
  input  wire logic signed [15:0]    in_lane_offset,
  input  wire logic [15:0]           in_lane_bend,
  input  wire logic                  in_both_edges,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_action,
  output logic [12:0]                out_forward_speed,
  output logic signed [12:0]         out_turn_rate,
  input  wire lfsc_pkg::lfsc_cmd_t   cmd,
  output lfsc_pkg::lfsc_sts_t        sts
);
  import lfsc_pkg::*;

  logic signed [19:0] xlo_r, xhi_r;
  logic [11:0]        sdist_r;
  logic [7:0]         slimit_r, esc_cfg_r, lost_cfg_r;
  logic [15:0]        curve_r;

  logic               finished_r, turning_r;
  logic signed [19:0] last_x_r, last_y_r;
  logic [7:0]         still_r, esc_r, lost_r;
  logic signed [15:0] prev_r, filt_r;

  logic signed [19:0] x_r, y_r;
  logic signed [14:0] hd_r;
  logic               seen_r, both_r;
  logic signed [15:0] off_r;
  logic [15:0]        bend_r;
  logic signed [16:0] d_r;
  logic signed [47:0] acc_r;
  logic signed [11:0] imu_r;
  logic signed [15:0] vis_r;
  logic signed [16:0] cmd_r;
  logic signed [12:0] trate_r;
  lfsc_cls_t          cls_r;

  logic               out_valid_r;
  logic [1:0]         out_action_r;
  logic [12:0]        out_speed_r;
  logic signed [12:0] out_rate_r;

  logic signed [20:0] dx, dy;
  logic signed [16:0] terr, herr;
  logic [16:0]        tmag;
  logic [21:0]        tn;
  logic signed [21:0] ma, mb;
  logic signed [43:0] prod;
  logic signed [36:0] rnd;
  logic [24:0]        tq;
  logic [12:0]        tclamp;
  logic               curve_one;
  logic               still, in_win, stuck;
  logic [7:0]         st_inc, lost_inc;
  lfsc_cls_t          cls_nxt;
  logic [1:0]         res_action;
  logic [12:0]        res_speed;
  logic signed [12:0] res_rate;

  assign dx   = 21'(x_r) - 21'(last_x_r);
  assign dy   = 21'(y_r) - 21'(last_y_r);
  assign terr = wrap_angle(17'(HalfPiQ) - 17'(hd_r));
  assign herr = wrap_angle(17'sd0 - 17'(hd_r));
  assign tmag = terr[16] ? 17'(-terr) : 17'(terr);
  assign tn   = (22'(tmag) << 2) + (22'(tmag) << 1) + 22'd5;
  assign curve_one = (cls_r == C_CRV) && !both_r;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.sel)
      M_DXDX:  begin ma = 22'(dx); mb = 22'(dx); end
      M_DYDY:  begin ma = 22'(dy); mb = 22'(dy); end
      M_SDSD:  begin ma = $signed(22'(sdist_r)); mb = $signed(22'(sdist_r)); end
      M_TURN:  begin ma = $signed(tn); mb = 22'(TurnRecip); end
      M_IMU:   begin ma = 22'(herr); mb = 22'(ImuGainQ); end
      M_KPOFF: begin
        ma = 22'(off_r);
        mb = curve_one ? 22'(KpCurveOneQ) : 22'(KpQ);
      end
      M_KDD:   begin
        ma = 22'(d_r);
        mb = curve_one ? 22'(KdCurveOneQ) : 22'(KdQ);
      end
      M_IMUW:  begin
        ma = 22'(imu_r);
        mb = both_r ? 22'(4096 - WBothQ) : 22'(4096 - WOneQ);
      end
      M_VISW:  begin ma = 22'(vis_r); mb = both_r ? 22'(WBothQ) : 22'(WOneQ); end
      M_FKEEP: begin ma = 22'(filt_r); mb = 22'(FiltKeepQ); end
      M_FNEW:  begin ma = 22'(cmd_r); mb = 22'(FiltNewQ); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;
  assign rnd  = rnd12(acc_r);
  assign tq   = acc_r[47:23];

  always_comb begin
    if (tq < 25'(TurnMin)) begin
      tclamp = 13'(TurnMin);
    end else if (tq > 25'(TurnMax)) begin
      tclamp = 13'(TurnMax);
    end else begin
      tclamp = tq[12:0];
    end
  end

  assign still    = acc_r[47];
  assign in_win   = (x_r >= xlo_r) && (x_r <= xhi_r);
  assign st_inc   = !still ? 8'd0 : (still_r == 8'hFF ? 8'hFF : still_r + 8'd1);
  assign stuck    = st_inc >= slimit_r;
  assign lost_inc = (lost_r == 8'hFF) ? 8'hFF : lost_r + 8'd1;

  always_comb begin
    if (finished_r) begin
      cls_nxt = C_FIN;
    end else if (turning_r) begin
      cls_nxt = (tmag <= 17'(TurnDoneTol)) ? C_TDONE : C_TURN;
    end else if (in_win) begin
      cls_nxt = C_JUNC;
    end else if (esc_r != 8'd0) begin
      cls_nxt = C_ESC;
    end else if (stuck) begin
      cls_nxt = C_STUCK;
    end else if (!seen_r) begin
      cls_nxt = C_LOST;
    end else if (bend_r < curve_r) begin
      cls_nxt = C_STR;
    end else begin
      cls_nxt = C_CRV;
    end
  end

  // config and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlo_r      <= 20'sd12083;
      xhi_r      <= 20'sd13107;
      sdist_r    <= 12'd41;
      slimit_r   <= 8'd30;
      esc_cfg_r  <= 8'd20;
      curve_r    <= 16'd960;
      lost_cfg_r <= 8'd10;
      finished_r <= 1'b0;
      turning_r  <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      still_r    <= '0;
      esc_r      <= '0;
      lost_r     <= '0;
      prev_r     <= '0;
      filt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_LOW:    xlo_r      <= cfg_data;
          CFG_X_HIGH:   xhi_r      <= cfg_data;
          CFG_STUCK_D:  sdist_r    <= cfg_data[11:0];
          CFG_STUCK_N:  slimit_r   <= cfg_data[7:0];
          CFG_ESCAPE_N: esc_cfg_r  <= cfg_data[7:0];
          CFG_CURVE:    curve_r    <= cfg_data[15:0];
          CFG_LOST_N:   lost_cfg_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (cls_nxt == C_TDONE) begin
          finished_r <= 1'b1;
        end
        if (cls_nxt == C_JUNC) begin
          turning_r <= 1'b1;
        end
        if (cls_nxt == C_ESC || cls_nxt == C_STUCK || cls_nxt == C_LOST ||
            cls_nxt == C_STR || cls_nxt == C_CRV) begin
          last_x_r <= x_r;
          last_y_r <= y_r;
        end
        if (cls_nxt == C_ESC) begin
          esc_r <= esc_r - 8'd1;
        end
        if (cls_nxt == C_STUCK) begin
          still_r <= 8'd0;
          esc_r   <= esc_cfg_r;
        end
        if (cls_nxt == C_LOST) begin
          still_r <= st_inc;
          lost_r  <= lost_inc;
        end
        if (cls_nxt == C_STR || cls_nxt == C_CRV) begin
          still_r <= st_inc;
          lost_r  <= 8'd0;
          prev_r  <= off_r;
        end
      end
      if (cmd.cap == CAP_FILT) begin
        if (rnd > 37'sd32767) begin
          filt_r <= 16'sh7FFF;
        end else if (rnd < -37'sd32768) begin
          filt_r <= 16'sh8000;
        end else begin
          filt_r <= 16'(rnd);
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_position_x;
      y_r    <= in_position_y;
      hd_r   <= in_heading;
      seen_r <= in_lane_seen;
      off_r  <= in_lane_offset;
      bend_r <= in_lane_bend;
      both_r <= in_both_edges;
    end
    if (cmd.commit) begin
      cls_r <= cls_nxt;
      d_r   <= 17'(off_r) - 17'(prev_r);
    end
    case (cmd.mode)
      MAC_CLR: acc_r <= 48'(prod);
      MAC_ADD: acc_r <= acc_r + 48'(prod);
      MAC_SUB: acc_r <= acc_r - 48'(prod);
      default: ;
    endcase
    case (cmd.cap)
      CAP_TURN: trate_r <= terr[16] ? -$signed(tclamp) : $signed(tclamp);
      CAP_IMU: begin
        if (rnd > 37'(ImuLimitQ)) begin
          imu_r <= 12'(ImuLimitQ);
        end else if (rnd < -37'(ImuLimitQ)) begin
          imu_r <= -12'(ImuLimitQ);
        end else begin
          imu_r <= 12'(rnd);
        end
      end
      CAP_PD: begin
        if (cls_r == C_STR) begin
          vis_r <= 16'(-rnd);
        end else begin
          cmd_r <= 17'(-rnd);
        end
      end
      CAP_CMD: cmd_r <= 17'(rnd);
      default: ;
    endcase
    if (cmd.emit) begin
      out_action_r <= res_action;
      out_speed_r  <= res_speed;
      out_rate_r   <= res_rate;
    end
  end

  always_comb begin
    res_action = ACT_NONE;
    res_speed  = '0;
    res_rate   = '0;
    case (cls_r)
      C_TDONE: res_action = ACT_FIN;
      C_TURN: begin
        res_action = ACT_VEL;
        res_rate   = trate_r;
      end
      C_JUNC: res_action = ACT_STOP;
      C_ESC: begin
        res_action = ACT_VEL;
        res_speed  = 13'(SpeedEscape);
      end
      C_LOST: res_action = (lost_r > lost_cfg_r) ? ACT_STOP : ACT_NONE;
      C_STR, C_CRV: begin
        res_action = ACT_VEL;
        res_speed  = (bend_r > curve_r) ? 13'(SpeedCurve) : 13'(SpeedBase);
        if (filt_r > 16'(YawLimitQ)) begin
          res_rate = 13'(YawLimitQ);
        end else if (filt_r < -16'(YawLimitQ)) begin
          res_rate = -13'(YawLimitQ);
        end else begin
          res_rate = 13'(filt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_forward_speed = out_speed_r;
  assign out_turn_rate     = out_rate_r;

  assign sts.cls_nxt  = cls_nxt;
  assign sts.cls      = cls_r;
  assign sts.out_free = !out_valid_r || out_ready;

  `LFSC_ASSERT_NXT(a_fin_sticky, clk, rst_n, finished_r, finished_r, "finished flag dropped")
  `LFSC_ASSERT_IMP(a_fin_turn, clk, rst_n, finished_r, turning_r, "finished without turn")
  `LFSC_ASSERT_IMP(a_idle_zero, clk, rst_n, out_valid_r && out_action_r != ACT_VEL,
                   out_speed_r == 13'd0 && out_rate_r == 13'sd0, "nonzero motion on non-velocity")

endmodule

`default_nettype wire

>>> hw/rtl/lfsc_ctrl.sv
// ----------------------------------------------------------------------------
// Lane follow steering controller sequencer
// Steps the shared multiply-accumulate unit through the products of one tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lane_follow_steering_controller_defines.svh"

module lfsc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lfsc_pkg::lfsc_sts_t  sts,
  output lfsc_pkg::lfsc_cmd_t       cmd
);
  import lfsc_pkg::*;

  lfsc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    cmd.emit   = 1'b0;
    cmd.mode   = MAC_HOLD;
    cmd.sel    = M_DXDX;
    cmd.cap    = CAP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DX;
        end
      end
      ST_DX: begin
        cmd.mode = MAC_CLR; cmd.sel = M_DXDX; state_nxt = ST_DY;
      end
      ST_DY: begin
        cmd.mode = MAC_ADD; cmd.sel = M_DYDY; state_nxt = ST_SD;
      end
      ST_SD: begin
        cmd.mode = MAC_SUB; cmd.sel = M_SDSD; state_nxt = ST_CLS;
      end
      ST_CLS: begin
        cmd.commit = 1'b1;
        unique case (sts.cls_nxt)
          C_TURN:  state_nxt = ST_T1;
          C_STR:   state_nxt = ST_H1;
          C_CRV:   state_nxt = ST_P1;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_T1: begin
        cmd.mode = MAC_CLR; cmd.sel = M_TURN; state_nxt = ST_T2;
      end
      ST_T2: begin
        cmd.cap = CAP_TURN; state_nxt = ST_DONE;
      end
      ST_H1: begin
        cmd.mode = MAC_CLR; cmd.sel = M_IMU; state_nxt = ST_H2;
      end
      ST_H2: begin
        cmd.cap = CAP_IMU; state_nxt = ST_P1;
      end
      ST_P1: begin
        cmd.mode = MAC_CLR; cmd.sel = M_KPOFF; state_nxt = ST_P2;
      end
      ST_P2: begin
        cmd.mode = MAC_ADD; cmd.sel = M_KDD; state_nxt = ST_P3;
      end
      ST_P3: begin
        cmd.cap   = CAP_PD;
        state_nxt = (sts.cls == C_STR) ? ST_B1 : ST_F1;
      end
      ST_B1: begin
        cmd.mode = MAC_CLR; cmd.sel = M_IMUW; state_nxt = ST_B2;
      end
      ST_B2: begin
        cmd.mode = MAC_ADD; cmd.sel = M_VISW; state_nxt = ST_B3;
      end
      ST_B3: begin
        cmd.cap = CAP_CMD; state_nxt = ST_F1;
      end
      ST_F1: begin
        cmd.mode = MAC_CLR; cmd.sel = M_FKEEP; state_nxt = ST_F2;
      end
      ST_F2: begin
        cmd.mode = MAC_ADD; cmd.sel = M_FNEW; state_nxt = ST_F3;
      end
      ST_F3: begin
        cmd.cap = CAP_FILT; state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `LFSC_ASSERT_NXT(a_start, clk, rst_n, in_valid && in_ready, state_r == ST_DX,
                   "transfer did not start a tick")
  `LFSC_ASSERT_NXT(a_return, clk, rst_n, state_r == ST_DONE && sts.out_free,
                   state_r == ST_IDLE, "result handed off but sequencer busy")
  `LFSC_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_r == ST_IDLE,
                   "input captured outside idle")

endmodule

`default_nettype wire

>>> hw/rtl/lane_follow_steering_controller.sv
// One drive command per control tick. After an input transfer, finished,
// junction, escape, stuck and lane-lost ticks go from the classification
// straight to the result; the junction turn adds the turn-rate product,
// lane following in curves the PD and filter products, and lane following
// on straights the heading, PD, blend and filter products. The next input
// is taken the cycle after the result enters the output register. The
// single shared 22x22 multiply-accumulate unit forms the displacement,
// heading, turn-rate, PD, blend and filter products in turn. The output
// register lets the next tick start while a result waits to be taken.
`default_nettype none

module lane_follow_steering_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [19:0] in_position_x,
  input  wire logic signed [19:0] in_position_y,
  input  wire logic signed [14:0] in_heading,
  input  wire logic               in_lane_seen,
  input  wire logic signed [15:0] in_lane_offset,
  input  wire logic [15:0]        in_lane_bend,
  input  wire logic               in_both_edges,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_action,
  output logic [12:0]             out_forward_speed,
  output logic signed [12:0]      out_turn_rate
);
  import lfsc_pkg::*;

  lfsc_cmd_t cmd;
  lfsc_sts_t sts;

  lfsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfsc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_position_x     (in_position_x),
    .in_position_y     (in_position_y),
    .in_heading        (in_heading),
    .in_lane_seen      (in_lane_seen),
    .in_lane_offset    (in_lane_offset),
    .in_lane_bend      (in_lane_bend),
    .in_both_edges     (in_both_edges),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_forward_speed (out_forward_speed),
    .out_turn_rate     (out_turn_rate),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

>>> test/lfsc_checker.sv
// ----------------------------------------------------------------------------
// Steering command checker
// Watches the tick, result and register ports of the lane follow steering
// controller. Predicts each drive command and compares it with the result taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfsc_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [19:0] in_position_x,
  input  wire logic signed [19:0] in_position_y,
  input  wire logic signed [14:0] in_heading,
  input  wire logic               in_lane_seen,
  input  wire logic signed [15:0] in_lane_offset,
  input  wire logic [15:0]        in_lane_bend,
  input  wire logic               in_both_edges,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [1:0]         out_action,
  input  wire logic [12:0]        out_forward_speed,
  input  wire logic signed [12:0] out_turn_rate,
  output int                      pending,
  output int                      errors
);
  import lfsc_pkg::*;

  typedef struct packed {
    logic [1:0]         act;
    logic [12:0]        spd;
    logic signed [12:0] rate;
  } drive_cmd_t;

  drive_cmd_t expected_cmds[$];

  logic signed [19:0] win_lo, win_hi;
  logic [11:0]        still_dist;
  logic [7:0]         still_limit, escape_len, lost_limit;
  logic [15:0]        bend_limit;

  logic               done, turning;
  logic signed [19:0] prev_x, prev_y;
  logic [7:0]         still_cnt, escape_cnt, lost_cnt;
  logic signed [15:0] prev_off, filt;

  function automatic longint q12(input longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + 2048) >>> 12;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint wrap(input longint a);
    if (a > PiQ) return a - TwoPiQ;
    if (a < -PiQ) return a + TwoPiQ;
    return a;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_drive_cmd(output drive_cmd_t c);
    longint x, y, hd, off, bend, err, mag, t, dx, dy, d, cmd, imu, w, vis, kp, kd, f;
    logic still;
    x = in_position_x; y = in_position_y; hd = in_heading;
    off = in_lane_offset; bend = in_lane_bend;
    c = '{ACT_NONE, 13'd0, 13'sd0};
    if (done) return;
    if (turning) begin
      err = wrap(HalfPiQ - hd);
      mag = err < 0 ? -err : err;
      if (mag <= TurnDoneTol) begin
        done = 1'b1;
        c.act = ACT_FIN;
        return;
      end
      t = clip((mag * 6 + 5) / 10, TurnMin, TurnMax);
      c.act = ACT_VEL;
      c.rate = 13'(err > 0 ? t : -t);
      return;
    end
    if (x >= win_lo && x <= win_hi) begin
      turning = 1'b1;
      c.act = ACT_STOP;
      return;
    end
    dx = x - prev_x;
    dy = y - prev_y;
    still = dx * dx + dy * dy < longint'(still_dist) * longint'(still_dist);
    prev_x = in_position_x;
    prev_y = in_position_y;
    if (escape_cnt > 0) begin
      escape_cnt--;
      c.act = ACT_VEL;
      c.spd = 13'(SpeedEscape);
      return;
    end
    if (still) begin
      if (still_cnt != 8'd255) still_cnt++;
    end else begin
      still_cnt = 8'd0;
    end
    if (still_cnt >= still_limit) begin
      still_cnt = 8'd0;
      escape_cnt = escape_len;
      return;
    end
    if (!in_lane_seen) begin
      if (lost_cnt != 8'd255) lost_cnt++;
      c.act = lost_cnt > lost_limit ? ACT_STOP : ACT_NONE;
      return;
    end
    lost_cnt = 8'd0;
    d = off - longint'(prev_off);
    prev_off = in_lane_offset;
    if (bend < bend_limit) begin
      imu = clip(q12(wrap(-hd) * ImuGainQ), -ImuLimitQ, ImuLimitQ);
      w = in_both_edges ? WBothQ : WOneQ;
      vis = -q12(KpQ * off + KdQ * d);
      cmd = q12(imu * (4096 - w) + vis * w);
    end else begin
      kp = in_both_edges ? KpQ : KpCurveOneQ;
      kd = in_both_edges ? KdQ : KdCurveOneQ;
      cmd = -q12(kp * off + kd * d);
    end
    f = clip(q12(FiltKeepQ * longint'(filt) + FiltNewQ * cmd), -32768, 32767);
    filt = 16'(f);
    c.act = ACT_VEL;
    c.spd = 13'(bend > bend_limit ? SpeedCurve : SpeedBase);
    c.rate = 13'(clip(f, -YawLimitQ, YawLimitQ));
  endtask

  always @(posedge clk) begin
    drive_cmd_t e, got;
    if (!rst_n) begin
      win_lo = 20'sd12083; win_hi = 20'sd13107; still_dist = 12'd41;
      still_limit = 8'd30; escape_len = 8'd20; bend_limit = 16'd960;
      lost_limit = 8'd10;
      done = 1'b0; turning = 1'b0; prev_x = '0; prev_y = '0;
      still_cnt = '0; escape_cnt = '0; lost_cnt = '0; prev_off = '0; filt = '0;
      expected_cmds.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_LOW:    win_lo = cfg_data;
          CFG_X_HIGH:   win_hi = cfg_data;
          CFG_STUCK_D:  still_dist = cfg_data[11:0];
          CFG_STUCK_N:  still_limit = cfg_data[7:0];
          CFG_ESCAPE_N: escape_len = cfg_data[7:0];
          CFG_CURVE:    bend_limit = cfg_data[15:0];
          CFG_LOST_N:   lost_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_action, out_forward_speed, out_turn_rate};
        if (expected_cmds.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: act=%0d spd=%0d rate=%0d",
                                     got.act, got.spd, got.rate);
        end else begin
          e = expected_cmds.pop_front();
          if (got !== e) begin
            errors++;
            if (errors <= 10)
              $display("command mismatch: exp act=%0d spd=%0d rate=%0d got act=%0d spd=%0d rate=%0d",
                       e.act, e.spd, e.rate, got.act, got.spd, got.rate);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_drive_cmd(e);
        expected_cmds.push_back(e);
      end
    end
    pending = expected_cmds.size();
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Lane follow steering controller testbench
// Directed ticks, then random odometry, heading and lane readings under
// several register settings, ending with junction turn and finish. Both
// channels stall in random bursts; a checker predicts every command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lfsc_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = CFG_X_LOW;
  logic [19:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [19:0] in_position_x = '0;
  logic signed [19:0] in_position_y = '0;
  logic signed [14:0] in_heading = '0;
  logic               in_lane_seen = 1'b0;
  logic signed [15:0] in_lane_offset = '0;
  logic [15:0]        in_lane_bend = '0;
  logic               in_both_edges = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_action;
  logic [12:0]        out_forward_speed;
  logic signed [12:0] out_turn_rate;
  int                 pending, errors;

  logic               quiet = 1'b0;
  int                 idle_cycles = 0;
  int                 ready_left = 0;
  logic signed [19:0] win_lo = 20'sd12083, win_hi = 20'sd13107;
  longint             pos_x = 0, pos_y = 0;
  int                 still_run = 0;
  int                 bend_ref = 960;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lane_follow_steering_controller dut (.*);

  lfsc_checker u_checker (.*);

  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      ready_left <= $urandom_range(1, 17) - 1;
    end else begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 40);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input longint x, input longint y, input longint hd,
                           input logic seen, input longint off, input longint bend,
                           input logic both);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position_x <= 20'(x);
    in_position_y <= 20'(y);
    in_heading <= 15'(hd);
    in_lane_seen <= seen;
    in_lane_offset <= 16'(off);
    in_lane_bend <= 16'(bend);
    in_both_edges <= both;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 20'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input longint lo, input longint hi, input longint sd,
                               input longint sn, input longint en, input longint cv,
                               input longint ln);
    drain();
    write_reg(CFG_X_LOW, lo);
    write_reg(CFG_X_HIGH, hi);
    write_reg(CFG_STUCK_D, sd);
    write_reg(CFG_STUCK_N, sn);
    write_reg(CFG_ESCAPE_N, en);
    write_reg(CFG_CURVE, cv);
    write_reg(CFG_LOST_N, ln);
    win_lo = 20'(lo);
    win_hi = 20'(hi);
    bend_ref = int'(cv);
  endtask

  task automatic random_ticks(input int n);
    longint x, hd, off, bend;
    int sel;
    repeat (n) begin
      if (still_run > 0) begin
        still_run--;
        pos_x += $urandom_range(0, 6) - 3;
        pos_y += $urandom_range(0, 6) - 3;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel == 0) still_run = $urandom_range(1, 40);
        if (sel == 1) begin
          pos_x = $signed(20'($urandom));
          pos_y = $signed(20'($urandom));
        end else begin
          pos_x += $urandom_range(0, 4000) - 2000;
          pos_y += $urandom_range(0, 4000) - 2000;
        end
      end
      pos_x = $signed(20'(pos_x));
      pos_y = $signed(20'(pos_y));
      x = pos_x;
      if (x >= win_lo && x <= win_hi) begin
        x = (win_hi != 20'sd524287) ? longint'(win_hi) + 1 : longint'(win_lo) - 1;
        pos_x = x;
      end
      hd = $urandom_range(0, 25736) - 12868;
      off = $urandom_range(0, 3) == 0 ? longint'($signed(16'($urandom)))
                                      : longint'($urandom_range(0, 8192)) - 4096;
      sel = $urandom_range(0, 3);
      bend = sel == 0 ? longint'($urandom_range(0, 65535))
           : sel == 1 ? longint'(bend_ref) + $urandom_range(0, 2) - 1
           : longint'($urandom_range(0, 2000));
      if (bend < 0) bend = 0;
      if (bend > 65535) bend = 65535;
      send_tick(x, pos_y, hd, $urandom_range(0, 9) != 0, off, bend, $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(0, 0, 0, 1, 0, 0, 1);
    send_tick(5000, 0, 12868, 1, 32767, 0, 1);
    send_tick(10000, 0, -12868, 1, -32768, 959, 0);
    send_tick(-20000, 300, 6000, 1, 32767, 960, 1);
    send_tick(-40000, 900, -6000, 1, -32768, 961, 0);
    send_tick(-60000, 2000, 100, 1, 1000, 65535, 0);
    send_tick(-80000, 524287, -100, 1, -1000, 65535, 1);
    send_tick(-524288, -524288, 3000, 1, 20000, 2000, 0);
    for (int i = 0; i < 12; i++) send_tick(-524288 + 5000 * i, 0, 0, 0, 0, 0, 1);
    send_tick(-460000, 0, 0, 1, 0, 0, 0);

    pos_x = -460000;
    random_ticks(500);
    apply_setting(524287, -524288, 41, 30, 20, 960, 10);
    random_ticks(450);
    apply_setting(0, -1, 4095, 1, 0, 0, 0);
    random_ticks(350);
    apply_setting(100000, 100000, 0, 255, 255, 65535, 255);
    random_ticks(350);
    apply_setting(-524288, -524000, 200, 5, 3, 960, 3);
    random_ticks(350);

    apply_setting(-524288, 524287, 4095, 255, 255, 65535, 255);
    quiet <= 1'b1;
    send_tick(0, 0, 0, 1, 0, 0, 1);
    send_tick(1, 1, -12868, 1, 0, 0, 1);
    send_tick(1, 1, 12868, 1, 0, 0, 1);
    send_tick(1, 1, 6434 - 205, 1, 0, 0, 1);
    send_tick(1, 1, 6434 + 205, 1, 0, 0, 1);
    send_tick(1, 1, -6434, 1, 0, 0, 1);
    for (int i = 0; i < 20; i++)
      send_tick(1, 1, $urandom_range(0, 25736) - 12868, 1, 0, 0, 1);
    send_tick(1, 1, 6434 + 204, 1, 0, 0, 1);
    random_ticks(20);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
